>>> hdl/arp_cache_responder_unit_assert.svh
// ---------------------------------------------------------------------------
// ARP cache responder assertion macros
// Wrappers for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef ARP_CACHE_RESPONDER_UNIT_ASSERT_SVH
`define ARP_CACHE_RESPONDER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ACR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("arp cache responder: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ACR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("arp cache responder: next-cycle check failed");

`endif

>>> hdl/acr_pkg.sv
// ---------------------------------------------------------------------------
// ARP cache responder package
// Shared constants, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
`default_nettype none

package acr_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam logic [7:0] TIMEOUT_RESET = 8'd15;

    // action codes
    localparam logic [1:0] ACT_REQUEST = 2'd0;
    localparam logic [1:0] ACT_REPLY   = 2'd1;
    localparam logic [1:0] ACT_TICK    = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_REPLY   = 3'd0;
    localparam logic [2:0] STAT_NOMATCH = 3'd1;
    localparam logic [2:0] STAT_REFRESH = 3'd2;
    localparam logic [2:0] STAT_INSERT  = 3'd3;
    localparam logic [2:0] STAT_FULL    = 3'd4;
    localparam logic [2:0] STAT_TICK    = 3'd5;

    localparam logic [6:0] EXPIRED_MAX = 7'd127;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

>>> hdl/acr_ctrl.sv
// ---------------------------------------------------------------------------
// ARP cache responder controller
// Sequences load, table sweep and result commit for one item at a time.
// ---------------------------------------------------------------------------
`default_nettype none

module acr_ctrl
    import acr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_DONE: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/acr_dp.sv
// ---------------------------------------------------------------------------
// ARP cache responder datapath
// Binding table memories, sweep pipeline, aging and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module acr_dp
    import acr_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic        i_cfg_wen,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic [1:0]  i_action,
    input  wire logic [31:0] i_spa,
    input  wire logic [47:0] i_sha,
    input  wire logic [31:0] i_tpa,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [2:0]       o_status,
    output logic [47:0]      o_reply_dst_mac,
    output logic [31:0]      o_reply_dst_ip,
    output logic [47:0]      o_reply_src_mac,
    output logic [31:0]      o_reply_src_ip,
    output logic [6:0]       o_expired_count
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam logic [IW:0] LAST_ADDR = (IW + 1)'(TABLE_ENTRIES);

    // table storage
    logic [31:0] m_ip  [TABLE_ENTRIES];
    logic [47:0] m_mac [TABLE_ENTRIES];
    logic [7:0]  m_age [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;

    logic [7:0]  r_timeout;

    // item being worked on
    logic [1:0]  r_action;
    logic [31:0] r_sip;
    logic [47:0] r_smac;
    logic [31:0] r_tip;

    // sweep pipeline
    logic [IW:0]   r_addr;
    logic          r_pv;
    logic [IW-1:0] r_pidx;
    logic [31:0]   r_rd_ip;
    logic [47:0]   r_rd_mac;
    logic [7:0]    r_rd_age;

    // search results
    logic          r_found;
    logic [IW-1:0] r_fidx;
    logic [47:0]   r_src_mac;
    logic [31:0]   r_src_ip;
    logic          r_free_found;
    logic [IW-1:0] r_free_idx;
    logic [6:0]    r_expired;

    logic          r_out_valid;

    logic          w_issue;
    logic [IW-1:0] w_raddr;
    logic [31:0]   w_key;
    logic          w_ent_v;
    logic          w_hit;
    logic          w_free;
    logic          w_tick_ent;
    logic [8:0]    w_age1;
    logic          w_expire;
    logic          w_fin_ref;
    logic          w_fin_ins;
    logic          w_wr_age;
    logic [7:0]    w_wage;
    logic [IW-1:0] w_waddr;

    assign w_issue    = i_cmd.scan && (r_addr != LAST_ADDR);
    assign w_raddr    = r_addr[IW-1:0];
    assign w_key      = (r_action == ACT_REQUEST) ? r_tip : r_sip;
    assign w_ent_v    = r_valid[r_pidx];
    assign w_hit      = r_pv && w_ent_v && (r_rd_ip == w_key);
    assign w_free     = r_pv && !w_ent_v;
    assign w_tick_ent = r_pv && w_ent_v && (r_action == ACT_TICK);
    assign w_age1     = {1'b0, r_rd_age} + 9'd1;
    assign w_expire   = w_age1 >= {1'b0, r_timeout};

    assign w_fin_ref = i_cmd.finish && (r_action == ACT_REPLY) && r_found;
    assign w_fin_ins = i_cmd.finish && (r_action == ACT_REPLY) && !r_found && r_free_found;

    assign w_wr_age = (w_tick_ent && !w_expire) || w_fin_ref || w_fin_ins;
    assign w_wage   = w_tick_ent ? w_age1[7:0] : 8'd0;
    assign w_waddr  = w_tick_ent ? r_pidx : (r_found ? r_fidx : r_free_idx);

    // memories: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_fin_ins) begin
            m_ip[w_waddr] <= r_sip;
        end
        if (w_fin_ref || w_fin_ins) begin
            m_mac[w_waddr] <= r_smac;
        end
        if (w_wr_age) begin
            m_age[w_waddr] <= w_wage;
        end
        r_rd_ip  <= m_ip[w_raddr];
        r_rd_mac <= m_mac[w_raddr];
        r_rd_age <= m_age[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_timeout <= TIMEOUT_RESET;
        end else begin
            if (i_cfg_wen) begin
                r_timeout <= i_cfg_wdata;
            end
            // drop expired entries, claim the free slot on insert
            if (w_tick_ent && w_expire) begin
                r_valid[r_pidx] <= 1'b0;
            end
            if (w_fin_ins) begin
                r_valid[r_free_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_sip    <= i_spa;
            r_smac   <= i_sha;
            r_tip    <= i_tpa;
        end
        if (w_hit && !r_found) begin
            r_fidx    <= r_pidx;
            r_src_mac <= r_rd_mac;
            r_src_ip  <= r_rd_ip;
        end
        if (w_free && !r_free_found) begin
            r_free_idx <= r_pidx;
        end
        if (w_issue) begin
            r_pidx <= w_raddr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_pv         <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_expired    <= '0;
        end else if (i_cmd.load) begin
            r_addr       <= '0;
            r_pv         <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_expired    <= '0;
        end else begin
            r_pv <= w_issue;
            if (w_issue) begin
                r_addr <= r_addr + 1'b1;
            end
            if (w_hit) begin
                r_found <= 1'b1;
            end
            if (w_free) begin
                r_free_found <= 1'b1;
            end
            if (w_tick_ent && w_expire && (r_expired != EXPIRED_MAX)) begin
                r_expired <= r_expired + 7'd1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_status        <= STAT_NOMATCH;
            o_reply_dst_mac <= '0;
            o_reply_dst_ip  <= '0;
            o_reply_src_mac <= '0;
            o_reply_src_ip  <= '0;
            o_expired_count <= '0;
            case (r_action)
                ACT_REQUEST: begin
                    if (r_found) begin
                        o_status        <= STAT_REPLY;
                        o_reply_dst_mac <= r_smac;
                        o_reply_dst_ip  <= r_sip;
                        o_reply_src_mac <= r_src_mac;
                        o_reply_src_ip  <= r_src_ip;
                    end
                end
                ACT_REPLY: begin
                    if (r_found) begin
                        o_status <= STAT_REFRESH;
                    end else if (r_free_found) begin
                        o_status <= STAT_INSERT;
                    end else begin
                        o_status <= STAT_FULL;
                    end
                end
                ACT_TICK: begin
                    o_status        <= STAT_TICK;
                    o_expired_count <= r_expired;
                end
                default: begin
                    o_status <= STAT_NOMATCH;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sts.scan_done = (r_addr == LAST_ADDR) && !r_pv;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

>>> hdl/arp_cache_responder_unit.sv
// ---------------------------------------------------------------------------
// ARP cache responder
// IPv4-to-MAC binding table with aging, answering parsed ARP traffic.
// ---------------------------------------------------------------------------
// Each accepted item (request, reply or one-second tick) produces exactly one
// result. Items are handled one at a time: every item sweeps the whole table
// through the single read port of the binding memories before its result is
// loaded, and it may then wait for the result register to drain. The next item
// is taken while a finished result still waits downstream. Requests answer
// from the lowest valid matching entry; replies refresh a match or insert
// into the lowest free slot; ticks age every valid entry and drop those
// reaching timeout_ticks. Write timeout_ticks only while the block is idle.
`default_nettype none

`include "arp_cache_responder_unit_assert.svh"

module arp_cache_responder_unit
    import acr_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_wen,
    input  wire logic [7:0]   i_cfg_wdata,    // timeout_ticks
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [111:0] s_axis_tdata,   // spa (sender IP), sha (sender MAC),
                                              // tpa (target IP)
    input  wire logic [1:0]   s_axis_tuser,   // action
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [167:0]      m_axis_tdata,   // reply_dst_mac, reply_dst_ip,
                                              // reply_src_mac, reply_src_ip,
                                              // expired_count, zero pad
    output logic [2:0]        m_axis_tuser    // status
);

    t_cmd w_cmd;
    t_sts w_sts;

    logic [47:0] w_dst_mac;
    logic [31:0] w_dst_ip;
    logic [47:0] w_src_mac;
    logic [31:0] w_src_ip;
    logic [6:0]  w_expired;

    acr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    acr_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_action        (s_axis_tuser),
        .i_spa           (s_axis_tdata[31:0]),
        .i_sha           (s_axis_tdata[79:32]),
        .i_tpa           (s_axis_tdata[111:80]),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_status        (m_axis_tuser),
        .o_reply_dst_mac (w_dst_mac),
        .o_reply_dst_ip  (w_dst_ip),
        .o_reply_src_mac (w_src_mac),
        .o_reply_src_ip  (w_src_ip),
        .o_expired_count (w_expired)
    );

    assign m_axis_tdata = {1'b0, w_expired, w_src_ip, w_src_mac, w_dst_ip, w_dst_mac};

    // one item in flight: no transfer is taken during the sweep
    `ACR_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // a committed result is presented on the next cycle
    `ACR_ASSERT_NEXT(a_finish_shows, i_clk, i_rst_n, w_cmd.finish, m_axis_tvalid)
    // expired count only rides on tick results
    `ACR_ASSERT_NOW(a_count_tick, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != STAT_TICK), w_expired == 7'd0)
    // reply fields only ride on reply results
    `ACR_ASSERT_NOW(a_fields_reply, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != STAT_REPLY), (w_src_ip == 32'd0) && (w_dst_mac == 48'd0))

endmodule

`default_nettype wire

>>> tb/sv/arp_cache_responder_unit_tb.sv
// ---------------------------------------------------------------------------
// ARP cache responder testbench
// Drives parsed ARP requests, replies and ticks through the input stream and
// checks each result against a binding-table model or a fixed directed value. A
// short directed table runs first, then random traffic in phases, with a
// timeout per phase and send/receive idle patterns changed at phases 2 and 4.
// ---------------------------------------------------------------------------
`default_nettype none

module arp_cache_responder_unit_tb;
    import acr_pkg::*;

    localparam int NUM_SLOTS     = TABLE_ENTRIES_DEF;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int IP_POOL_SIZE  = 72;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int NUM_DIRECTED  = 16;
    localparam int NUM_PHASES    = 7;
    localparam int FILL_TIMEOUT  = 255;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] dst_mac;
        logic [31:0] dst_ip;
        logic [47:0] src_mac;
        logic [31:0] src_ip;
        logic [6:0]  expired;
    } t_arp_result;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] spa;
        logic [47:0] sha;
        logic [31:0] tpa;
        logic        fixed;
        t_arp_result result;
    } t_directed_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wen = 1'b0;
    logic [7:0]   i_cfg_wdata = TIMEOUT_RESET;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata = '0;   // spa (sender IP), sha (sender MAC), tpa (target IP)
    logic [1:0]   s_axis_tuser = '0;   // action
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [167:0] m_axis_tdata;        // reply_dst_mac, reply_dst_ip, reply_src_mac,
                                       // reply_src_ip, expired_count, zero pad
    logic [2:0]   m_axis_tuser;        // status

    // binding table as the block should hold it
    bit           tbl_valid [NUM_SLOTS];
    logic [31:0]  tbl_ip    [NUM_SLOTS];
    logic [47:0]  tbl_mac   [NUM_SLOTS];
    int unsigned  tbl_age   [NUM_SLOTS];
    logic [7:0]   timeout_cfg = TIMEOUT_RESET;

    t_arp_result  expected_results [$];
    logic [31:0]  ip_pool [IP_POOL_SIZE];
    int           send_idle_pct = 25;
    int           recv_idle_pct = 56;
    int           mismatches = 0;
    int           quiet_cycles = 0;

    int phase_timeout [NUM_PHASES] = '{15, 1, 255, 0, 0, 0, 8};
    int phase_items   [NUM_PHASES] = '{180, 150, 250, 100, 200, 200, 150};

    t_directed_row directed_rows [NUM_DIRECTED] = '{
        // empty table: nothing matches, a tick removes nothing
        '{ACT_REQUEST, 32'h0, 48'h0, 32'h0, 1'b1,
           '{STAT_NOMATCH, 48'h0, 32'h0, 48'h0, 32'h0, 7'd0}},
        '{ACT_UNUSED, 32'hFFFFFFFF, 48'hFFFFFFFFFFFF, 32'hFFFFFFFF, 1'b1,
           '{STAT_NOMATCH, 48'h0, 32'h0, 48'h0, 32'h0, 7'd0}},
        '{ACT_TICK, 32'h0, 48'h0, 32'h0, 1'b1,
           '{STAT_TICK, 48'h0, 32'h0, 48'h0, 32'h0, 7'd0}},
        '{ACT_REPLY, 32'h0, 48'h0, 32'hFFFFFFFF, 1'b1,
           '{STAT_INSERT, 48'h0, 32'h0, 48'h0, 32'h0, 7'd0}},
        '{ACT_REPLY, 32'hFFFFFFFF, 48'hFFFFFFFFFFFF, 32'h0, 1'b1,
           '{STAT_INSERT, 48'h0, 32'h0, 48'h0, 32'h0, 7'd0}},
        '{ACT_REQUEST, 32'h0A000001, 48'h112233445566, 32'hFFFFFFFF, 1'b1,
           '{STAT_REPLY, 48'h112233445566, 32'h0A000001,
             48'hFFFFFFFFFFFF, 32'hFFFFFFFF, 7'd0}},
        '{ACT_REQUEST, 32'hFFFFFFFF, 48'hFFFFFFFFFFFF, 32'h0, 1'b1,
           '{STAT_REPLY, 48'hFFFFFFFFFFFF, 32'hFFFFFFFF, 48'h0, 32'h0, 7'd0}},
        '{ACT_REPLY, 32'h0, 48'hA5A5A5A5A5A5, 32'h0, 1'b1,
           '{STAT_REFRESH, 48'h0, 32'h0, 48'h0, 32'h0, 7'd0}},
        '{ACT_REQUEST, 32'hC0A80001, 48'h5A5A5A5A5A5A, 32'h0, 1'b0, '0},
        '{ACT_REQUEST, 32'h0, 48'h0, 32'h12345678, 1'b1,
           '{STAT_NOMATCH, 48'h0, 32'h0, 48'h0, 32'h0, 7'd0}},
        '{ACT_REPLY, 32'h12345678, 48'h0000DEADBEEF, 32'h0, 1'b0, '0},
        '{ACT_REQUEST, 32'h80000000, 48'h800000000000, 32'h12345678, 1'b0, '0},
        '{ACT_TICK, 32'hFFFFFFFF, 48'hFFFFFFFFFFFF, 32'hFFFFFFFF, 1'b0, '0},
        '{ACT_REPLY, 32'hFFFFFFFF, 48'h123456789ABC, 32'h0, 1'b0, '0},
        // unused action must leave the table alone
        '{ACT_UNUSED, 32'h12345678, 48'h0, 32'h12345678, 1'b1,
           '{STAT_NOMATCH, 48'h0, 32'h0, 48'h0, 32'h0, 7'd0}},
        '{ACT_REQUEST, 32'h7FFFFFFF, 48'h7FFFFFFFFFFF, 32'hFFFFFFFF, 1'b0, '0}
    };

    arp_cache_responder_unit #(
        .TABLE_ENTRIES (NUM_SLOTS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [47:0] rand_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    // Apply one item to the table model and return the result it must give.
    function automatic t_arp_result resolve_arp_item(input logic [1:0] action,
                                                     input logic [31:0] sip,
                                                     input logic [47:0] smac,
                                                     input logic [31:0] tip);
        t_arp_result res;
        int hit;
        int free_slot;
        int removed;
        int k;
        res = '0;
        res.status = STAT_NOMATCH;
        hit = -1;
        free_slot = -1;
        removed = 0;
        case (action)
            ACT_REQUEST: begin
                for (k = NUM_SLOTS - 1; k >= 0; k--)
                    if (tbl_valid[k] && tbl_ip[k] == tip) hit = k;
                if (hit >= 0) begin
                    res.status  = STAT_REPLY;
                    res.dst_mac = smac;
                    res.dst_ip  = sip;
                    res.src_mac = tbl_mac[hit];
                    res.src_ip  = tbl_ip[hit];
                end
            end
            ACT_REPLY: begin
                for (k = NUM_SLOTS - 1; k >= 0; k--) begin
                    if (tbl_valid[k] && tbl_ip[k] == sip) hit = k;
                    if (!tbl_valid[k]) free_slot = k;
                end
                if (hit >= 0) begin
                    tbl_mac[hit] = smac;
                    tbl_age[hit] = 0;
                    res.status = STAT_REFRESH;
                end else if (free_slot >= 0) begin
                    tbl_valid[free_slot] = 1'b1;
                    tbl_ip[free_slot]    = sip;
                    tbl_mac[free_slot]   = smac;
                    tbl_age[free_slot]   = 0;
                    res.status = STAT_INSERT;
                end else begin
                    res.status = STAT_FULL;
                end
            end
            ACT_TICK: begin
                for (k = 0; k < NUM_SLOTS; k++) begin
                    if (tbl_valid[k]) begin
                        if (tbl_age[k] + 1 >= timeout_cfg) begin
                            tbl_valid[k] = 1'b0;
                            tbl_age[k] = 0;
                            if (removed < int'(EXPIRED_MAX)) removed++;
                        end else begin
                            tbl_age[k] = tbl_age[k] + 1;
                        end
                    end
                end
                res.status  = STAT_TICK;
                res.expired = removed[6:0];
            end
            default: ;
        endcase
        return res;
    endfunction

    // Present one item, hold it until the transfer, then queue its result.
    // tvalid stays high on return so back-to-back items need no second write.
    task automatic send_item(input logic [1:0] action, input logic [31:0] sip,
                             input logic [47:0] smac, input logic [31:0] tip,
                             input bit fixed, input t_arp_result fixed_res);
        t_arp_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= {tip, smac, sip};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = resolve_arp_item(action, sip, smac, tip);
        expected_results.push_back(fixed ? fixed_res : predicted);
    endtask

    // Drain the block, then write the timeout register.
    task automatic write_timeout(input logic [7:0] value);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        timeout_cfg = value;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Result side: random stalls, checking, and the no-progress watchdog.
    always @(posedge i_clk) begin
        t_arp_result got;
        t_arp_result want;
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tuser, m_axis_tdata[47:0], m_axis_tdata[79:48],
                    m_axis_tdata[127:80], m_axis_tdata[159:128],
                    m_axis_tdata[166:160]};
            if (expected_results.size() == 0) begin
                $error("result with status %0d arrived with nothing expected",
                       got.status);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", 64'(want.status), 64'(got.status));
                check_field("reply_dst_mac", 64'(want.dst_mac), 64'(got.dst_mac));
                check_field("reply_dst_ip", 64'(want.dst_ip), 64'(got.dst_ip));
                check_field("reply_src_mac", 64'(want.src_mac), 64'(got.src_mac));
                check_field("reply_src_ip", 64'(want.src_ip), 64'(got.src_ip));
                check_field("expired_count", 64'(want.expired), 64'(got.expired));
            end
        end
        if (i_rst_n && !((s_axis_tvalid && s_axis_tready) ||
                         (m_axis_tvalid && m_axis_tready))) begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("arp_cache_responder_unit_tb: done, errors");
                $finish;
            end
        end else begin
            quiet_cycles = 0;
        end
    end

    initial begin
        int phase;
        int sent;
        int k;
        int sel;
        logic [1:0]  act;
        logic [31:0] sip;
        logic [47:0] smac;
        logic [31:0] tip;

        ip_pool[0] = 32'h0;
        ip_pool[1] = 32'hFFFFFFFF;
        for (k = 2; k < IP_POOL_SIZE; k++) ip_pool[k] = $urandom;
        phase_timeout[4] = $urandom_range(2, 254);
        phase_timeout[5] = $urandom_range(2, 254);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r])
            send_item(directed_rows[r].action, directed_rows[r].spa,
                      directed_rows[r].sha, directed_rows[r].tpa,
                      directed_rows[r].fixed, directed_rows[r].result);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == 2) begin
                send_idle_pct = 56;
                recv_idle_pct = 25;
            end else if (phase == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // first phase runs on the reset timeout
            if (phase != 0) write_timeout(8'(phase_timeout[phase]));
            sent = 0;
            // with the longest timeout, learn the whole pool to overflow the table
            if (phase_timeout[phase] == FILL_TIMEOUT) begin
                for (k = 0; k < IP_POOL_SIZE; k++)
                    send_item(ACT_REPLY, ip_pool[k], rand_mac(), $urandom, 1'b0, '0);
                sent = IP_POOL_SIZE;
            end
            while (sent < phase_items[phase]) begin
                sel  = $urandom_range(99);
                sip  = $urandom;
                smac = rand_mac();
                tip  = $urandom;
                if (sel < 35) begin
                    act = ACT_REPLY;
                    sip = ip_pool[$urandom_range(IP_POOL_SIZE - 1)];
                end else if (sel < 70) begin
                    act = ACT_REQUEST;
                    tip = ip_pool[$urandom_range(IP_POOL_SIZE - 1)];
                end else if (sel < 80) begin
                    act = ACT_TICK;
                end else if (sel < 90) begin
                    act = ACT_REQUEST;
                end else begin
                    act = 2'($urandom_range(3));
                end
                send_item(act, sip, smac, tip, 1'b0, '0);
                if (act != ACT_UNUSED) sent++;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("arp_cache_responder_unit_tb: done, clean");
        end else begin
            $display("arp_cache_responder_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
